[rtl/mtdf_pkg.sv]
package mtdf_pkg;

    localparam int SOURCE_ENTRIES     = 8;
    localparam int SERIALS_PER_SOURCE = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_USER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_DEVICE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_USER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_USER = 2'd3;

    localparam logic [31:0] SUPER_USER_RESET = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_COMPLETE   = 3'd0;
    localparam logic [2:0] ST_USER_ERR   = 3'd1;
    localparam logic [2:0] ST_REPEAT     = 3'd2;
    localparam logic [2:0] ST_TARGET_ERR = 3'd3;
    localparam logic [2:0] ST_NO_CMD     = 3'd4;

    localparam logic [1:0] TARGET_SINGLE = 2'd0;
    localparam logic [1:0] TARGET_ALL    = 2'd1;

    typedef struct packed {
        logic [31:0] msg_user_id;
        logic [31:0] source_address;
        logic [7:0]  serial_number;
        logic [1:0]  target_kind;
        logic [31:0] target_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] reply_address;
        logic [31:0] last_broadcast_source;
    } t_rsp;

endpackage

[rtl/message_target_and_duplicate_filter.sv]
// Checks one received message header per request and returns exactly one result,
// shown on o_rsp for the single cycle in which o_done is high; the receiver cannot
// stall, so the result must be captured in that cycle. A request is taken when start
// is high and busy is low. A message that fails the user check is answered in the
// next cycle. Any other message scans the source table, one row read per cycle from
// a single RAM with a registered read; a message from a known source then updates
// that row unless the serial is a repeat, and a message from an unknown source
// reads and rewrites the next victim row. Each RAM row holds one source address,
// its ring pointer and its recent serial numbers; a row never written reads as zero.
// Configuration registers may be written only while busy is low.
module message_target_and_duplicate_filter #(
    parameter int SOURCE_ENTRIES     = mtdf_pkg::SOURCE_ENTRIES,
    parameter int SERIALS_PER_SOURCE = mtdf_pkg::SERIALS_PER_SOURCE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mtdf_pkg::t_req                   i_req,
    output logic                             o_done,
    output mtdf_pkg::t_rsp                   o_rsp,
    input  logic                             i_cfg_we,
    input  logic [mtdf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mtdf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = $clog2(SOURCE_ENTRIES);
    localparam int SW = $clog2(SERIALS_PER_SOURCE);
    localparam int HW = 8 * SERIALS_PER_SOURCE;
    localparam int RW = 32 + SW + HW;

    localparam logic [IW-1:0] LAST_ENTRY = IW'(SOURCE_ENTRIES - 1);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(SERIALS_PER_SOURCE - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_HIT    = 3'd2;
    localparam logic [2:0] S_VREAD  = 3'd3;
    localparam logic [2:0] S_VWRITE = 3'd4;

    logic [2:0]                r_state;
    logic [IW-1:0]             r_idx;
    logic                      r_chk;
    logic [IW-1:0]             r_vp;
    logic [SOURCE_ENTRIES-1:0] r_valid;
    logic [31:0]               r_bsrc;
    logic [31:0]               r_own_user;
    logic [31:0]               r_own_device;
    logic [31:0]               r_super_user;
    logic [31:0]               r_default_user;
    logic                      r_done;

    mtdf_pkg::t_req            r_req;
    mtdf_pkg::t_rsp            r_rsp;
    logic [RW-1:0]             r_row;
    logic [IW-1:0]             r_hit_idx;
    logic [IW-1:0]             r_rd_idx;

    logic                      w_accept;
    logic                      w_user_ok;
    logic [IW-1:0]             w_raddr;
    logic [RW-1:0]             w_rdata;
    logic [RW-1:0]             w_row;
    logic                      w_match;
    logic                      w_repeat;
    logic [SW-1:0]             w_next_slot;
    logic [RW-1:0]             w_hit_row;
    logic [RW-1:0]             w_victim_row;
    logic                      w_we;
    logic [IW-1:0]             w_waddr;
    logic [RW-1:0]             w_wdata;
    mtdf_pkg::t_rsp            w_pass_rsp;
    logic [31:0]               w_bsrc_n;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_done   = r_done;
    assign o_rsp    = r_rsp;

    assign w_user_ok = (i_req.msg_user_id == r_own_user) ||
                       (i_req.msg_user_id == r_super_user) ||
                       (r_own_user == r_default_user);

    always_comb begin
        unique case (r_state) inside
            S_VREAD, S_VWRITE: w_raddr = r_vp;
            default:           w_raddr = r_idx;
        endcase
    end

    mtdf_ram #(
        .WIDTH(RW),
        .DEPTH(SOURCE_ENTRIES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Rows that were never written read as zero, masked by their valid bits.
    assign w_row   = r_valid[r_rd_idx] ? w_rdata : '0;
    assign w_match = (w_row[RW-1 -: 32] == r_req.source_address);

    always_comb begin
        w_repeat = 1'b0;
        for (int s = 0; s < SERIALS_PER_SOURCE; s++) begin
            if (r_row[8*s +: 8] == r_req.serial_number) begin
                w_repeat = 1'b1;
            end
        end
        w_next_slot = (r_row[HW +: SW] == LAST_SLOT) ? '0 : r_row[HW +: SW] + 1'b1;
        w_hit_row = r_row;
        w_hit_row[HW +: SW] = w_next_slot;
        for (int s = 0; s < SERIALS_PER_SOURCE; s++) begin
            if (SW'(s) == w_next_slot) begin
                w_hit_row[8*s +: 8] = r_req.serial_number;
            end
        end
    end

    // A replaced entry keeps its ring pointer and older serials.
    always_comb begin
        w_victim_row = w_row;
        w_victim_row[RW-1 -: 32] = r_req.source_address;
        w_victim_row[7:0] = r_req.serial_number;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hit_idx;
        w_wdata = w_hit_row;
        if (r_state == S_HIT) begin
            w_we = !w_repeat;
        end else if (r_state == S_VWRITE) begin
            w_we    = 1'b1;
            w_waddr = r_vp;
            w_wdata = w_victim_row;
        end
    end

    // Target check for a message that passed the duplicate filter.
    always_comb begin
        w_bsrc_n = r_bsrc;
        w_pass_rsp.reply_address = r_req.target_address;
        if (r_req.target_kind == mtdf_pkg::TARGET_SINGLE) begin
            if (r_req.target_address != r_own_device) begin
                w_pass_rsp.status = mtdf_pkg::ST_TARGET_ERR;
            end else begin
                w_pass_rsp.status = mtdf_pkg::ST_COMPLETE;
                w_pass_rsp.reply_address = r_req.source_address;
                w_bsrc_n = '0;
            end
        end else if (r_req.target_kind == mtdf_pkg::TARGET_ALL &&
                     r_req.target_address == '0) begin
            w_pass_rsp.status = mtdf_pkg::ST_COMPLETE;
            w_pass_rsp.reply_address = r_req.source_address;
            w_bsrc_n = r_req.source_address;
        end else begin
            w_pass_rsp.status = mtdf_pkg::ST_NO_CMD;
        end
        w_pass_rsp.last_broadcast_source = w_bsrc_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_idx          <= '0;
            r_chk          <= 1'b0;
            r_vp           <= '0;
            r_valid        <= '0;
            r_bsrc         <= '0;
            r_own_user     <= '0;
            r_own_device   <= '0;
            r_super_user   <= mtdf_pkg::SUPER_USER_RESET;
            r_default_user <= '0;
            r_done         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mtdf_pkg::REG_OWN_USER:     r_own_user     <= i_cfg_data;
                    mtdf_pkg::REG_OWN_DEVICE:   r_own_device   <= i_cfg_data;
                    mtdf_pkg::REG_SUPER_USER:   r_super_user   <= i_cfg_data;
                    mtdf_pkg::REG_DEFAULT_USER: r_default_user <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_done <= w_accept && !w_user_ok;
                    if (w_accept) begin
                        r_idx <= '0;
                        r_chk <= 1'b0;
                        if (w_user_ok) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_done <= 1'b0;
                    if (r_chk && w_match) begin
                        r_state <= S_HIT;
                    end else if (r_chk && r_rd_idx == LAST_ENTRY) begin
                        r_vp    <= (r_vp == LAST_ENTRY) ? '0 : r_vp + 1'b1;
                        r_state <= S_VREAD;
                    end else begin
                        r_idx <= (r_idx == LAST_ENTRY) ? '0 : r_idx + 1'b1;
                        r_chk <= 1'b1;
                    end
                end
                S_HIT: begin
                    if (!w_repeat) begin
                        r_bsrc <= w_bsrc_n;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_VREAD: begin
                    r_done  <= 1'b0;
                    r_state <= S_VWRITE;
                end
                S_VWRITE: begin
                    r_bsrc  <= w_bsrc_n;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_raddr;
        if (w_accept) begin
            r_req <= i_req;
            r_rsp.status                <= mtdf_pkg::ST_USER_ERR;
            r_rsp.reply_address         <= i_req.target_address;
            r_rsp.last_broadcast_source <= r_bsrc;
        end
        if (r_state == S_SCAN && r_chk && w_match) begin
            r_row     <= w_row;
            r_hit_idx <= r_rd_idx;
        end
        if (r_state == S_HIT) begin
            if (w_repeat) begin
                r_rsp.status                <= mtdf_pkg::ST_REPEAT;
                r_rsp.reply_address         <= r_req.target_address;
                r_rsp.last_broadcast_source <= r_bsrc;
            end else begin
                r_rsp <= w_pass_rsp;
            end
        end
        if (r_state == S_VWRITE) begin
            r_rsp <= w_pass_rsp;
        end
    end

endmodule

[rtl/mtdf_ram.sv]
module mtdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[verif/header_filter_checker.sv]
`timescale 1ns / 1ps

module header_filter_checker
    import mtdf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_req                   i_req,
    input  logic                   i_done,
    input  t_rsp                   i_rsp,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int unsigned            o_mismatches,
    output int unsigned            o_pending,
    output logic [4:0][15:0]       o_tally
);

    // Register copies.
    logic [31:0] own_user;
    logic [31:0] own_device;
    logic [31:0] super_user;
    logic [31:0] default_user;

    // Duplicate filter state.
    logic [31:0] known_src [SOURCE_ENTRIES];
    logic [7:0]  recent_serial [SOURCE_ENTRIES][SERIALS_PER_SOURCE];
    int unsigned ring_pos [SOURCE_ENTRIES];
    int unsigned victim;
    logic [31:0] bcast_src;

    t_rsp             awaited_replies[$];
    int unsigned      mismatch_count;
    int unsigned      reply_count;
    logic [4:0][15:0] status_tally;

    task automatic report_mismatch(input string what);
        $display("checker: reply %0d: %s", reply_count, what);
        mismatch_count++;
    endtask

    // Returns 1 on a repeated serial; otherwise records the serial.
    function automatic logic seen_before(input logic [31:0] src, input logic [7:0] serial);
        int unsigned nxt;
        for (int e = 0; e < SOURCE_ENTRIES; e++) begin
            if (known_src[e] == src) begin
                for (int s = 0; s < SERIALS_PER_SOURCE; s++) begin
                    if (recent_serial[e][s] == serial) return 1'b1;
                end
                nxt = (ring_pos[e] + 1) % SERIALS_PER_SOURCE;
                ring_pos[e] = nxt;
                recent_serial[e][nxt] = serial;
                return 1'b0;
            end
        end
        // An unknown source replaces the next victim and writes only slot 0.
        victim = (victim + 1) % SOURCE_ENTRIES;
        recent_serial[victim][0] = serial;
        known_src[victim] = src;
        return 1'b0;
    endfunction

    function automatic t_rsp screen_header(input t_req m);
        t_rsp r;
        r.reply_address = m.target_address;
        if (!(m.msg_user_id == own_user || m.msg_user_id == super_user ||
              own_user == default_user)) begin
            r.status = ST_USER_ERR;
        end else if (seen_before(m.source_address, m.serial_number)) begin
            r.status = ST_REPEAT;
        end else if (m.target_kind == TARGET_SINGLE) begin
            if (m.target_address != own_device) begin
                r.status = ST_TARGET_ERR;
            end else begin
                bcast_src = '0;
                r.reply_address = m.source_address;
                r.status = ST_COMPLETE;
            end
        end else if (m.target_kind == TARGET_ALL && m.target_address == '0) begin
            bcast_src = m.source_address;
            r.reply_address = m.source_address;
            r.status = ST_COMPLETE;
        end else begin
            r.status = ST_NO_CMD;
        end
        r.last_broadcast_source = bcast_src;
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        reply_count = 0;
        status_tally = '0;
        o_mismatches = 0;
        o_pending = 0;
        o_tally = '0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            own_user = '0;
            own_device = '0;
            super_user = SUPER_USER_RESET;
            default_user = '0;
            for (int e = 0; e < SOURCE_ENTRIES; e++) begin
                known_src[e] = '0;
                ring_pos[e] = 0;
                for (int s = 0; s < SERIALS_PER_SOURCE; s++) recent_serial[e][s] = '0;
            end
            victim = 0;
            bcast_src = '0;
            awaited_replies.delete();
        end else begin
            if (i_done) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, status %0d",
                                              i_rsp.status));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, want.status));
                    if (i_rsp.reply_address !== want.reply_address)
                        report_mismatch($sformatf("reply_address %h, expected %h",
                                                  i_rsp.reply_address, want.reply_address));
                    if (i_rsp.last_broadcast_source !== want.last_broadcast_source)
                        report_mismatch($sformatf("last_broadcast_source %h, expected %h",
                                                  i_rsp.last_broadcast_source,
                                                  want.last_broadcast_source));
                end
                reply_count++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OWN_USER:     own_user = i_cfg_data;
                    REG_OWN_DEVICE:   own_device = i_cfg_data;
                    REG_SUPER_USER:   super_user = i_cfg_data;
                    REG_DEFAULT_USER: default_user = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                want = screen_header(i_req);
                awaited_replies.push_back(want);
                status_tally[want.status] = status_tally[want.status] + 16'd1;
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= awaited_replies.size();
        o_tally <= status_tally;
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mtdf_pkg::*;

    localparam int          PHASE_ITEMS = 86;
    localparam int          POOL_SIZE   = 12;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_req                  i_req;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int unsigned      mismatches;
    int unsigned      pending;
    logic [4:0][15:0] tally;

    // Register values as last written, used to aim the stimulus.
    logic [31:0] cfg_own_user;
    logic [31:0] cfg_own_device;
    logic [31:0] cfg_super_user;
    logic [31:0] cfg_default_user;

    logic [31:0] src_pool [POOL_SIZE];
    int unsigned talker;
    logic [7:0]  talker_serial;
    logic        steady;
    int unsigned sent;
    int unsigned settings;
    int unsigned cycle_count;

    message_target_and_duplicate_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    header_filter_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_tally      (tally)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: timed out after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic t_req hdr(input logic [31:0] user, input logic [31:0] src,
                                 input logic [7:0] serial, input logic [1:0] kind,
                                 input logic [31:0] tgt);
        t_req m;
        m.msg_user_id = user;
        m.source_address = src;
        m.serial_number = serial;
        m.target_kind = kind;
        m.target_address = tgt;
        return m;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        case (idx)
            REG_OWN_USER:     cfg_own_user = value;
            REG_OWN_DEVICE:   cfg_own_device = value;
            REG_SUPER_USER:   cfg_super_user = value;
            REG_DEFAULT_USER: cfg_default_user = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] own_u, input logic [31:0] own_d,
                            input logic [31:0] super_u, input logic [31:0] default_u);
        write_reg(REG_OWN_USER, own_u);
        write_reg(REG_OWN_DEVICE, own_d);
        write_reg(REG_SUPER_USER, super_u);
        write_reg(REG_DEFAULT_USER, default_u);
        settings++;
    endtask

    // Stops requests and waits until every reply is in and the block is idle.
    task automatic wait_idle(input int unsigned tail);
        @(negedge i_clk);
        start = 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic send_header(input t_req m);
        if (!steady) begin
            while ($urandom_range(99) < 37) begin
                @(negedge i_clk);
                start = 1'b0;
                i_req = t_req'({$urandom, $urandom, $urandom, $urandom});
            end
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req = m;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // Mostly conversations from a small set of senders with rising serials and
    // the odd retransmission; the rest is noise over the full field ranges.
    function automatic t_req pick_header();
        t_req        m;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) m.msg_user_id = cfg_own_user;
        else if (roll < 75) m.msg_user_id = cfg_super_user;
        else if (roll < 80) m.msg_user_id = cfg_default_user;
        else m.msg_user_id = $urandom;

        if ($urandom_range(99) < 70) begin
            if ($urandom_range(99) < 15) begin
                talker = $urandom_range(POOL_SIZE - 1);
                talker_serial = 8'($urandom_range(255));
            end else if ($urandom_range(99) >= 20) begin
                talker_serial = talker_serial + 8'd1;
            end
            m.source_address = src_pool[talker];
            m.serial_number = talker_serial;
        end else begin
            m.source_address = ($urandom_range(3) == 0) ? $urandom
                                                        : src_pool[$urandom_range(POOL_SIZE - 1)];
            m.serial_number = ($urandom_range(1) == 0) ? 8'($urandom_range(7))
                                                       : 8'($urandom_range(255));
        end

        roll = $urandom_range(99);
        if (roll < 45) m.target_kind = TARGET_SINGLE;
        else if (roll < 80) m.target_kind = TARGET_ALL;
        else m.target_kind = 2'($urandom_range(2, 3));

        roll = $urandom_range(99);
        if (m.target_kind == TARGET_SINGLE)
            m.target_address = (roll < 80) ? cfg_own_device : $urandom;
        else if (m.target_kind == TARGET_ALL)
            m.target_address = (roll < 80) ? 32'd0 : $urandom;
        else
            m.target_address = (roll < 30) ? 32'd0 : $urandom;
        return m;
    endfunction

    task automatic run_phase(input logic pause_midway);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (pause_midway && n == PHASE_ITEMS / 2) wait_idle(0);
            send_header(pick_header());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cfg_own_user = '0;
        cfg_own_device = '0;
        cfg_super_user = SUPER_USER_RESET;
        cfg_default_user = '0;
        steady = 1'b0;
        sent = 0;
        settings = 0;
        cycle_count = 0;
        talker = 0;
        talker_serial = '0;
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        for (int p = 2; p < POOL_SIZE; p++) src_pool[p] = $urandom;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers accept every user; the zero source already holds serial 0.
        send_header(hdr(32'h0, 32'h0, 8'h00, TARGET_SINGLE, 32'h0));
        send_header(hdr(32'h0, 32'h0, 8'h01, TARGET_SINGLE, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h00, TARGET_ALL, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h00, TARGET_ALL, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h01, TARGET_ALL, 32'h5));
        send_header(hdr(32'h0, 32'h11, 8'h02, 2'd2, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h03, 2'd3, 32'hFFFF_FFFF));
        // The filter records the serial even though the target check fails.
        send_header(hdr(32'h0, 32'h11, 8'h04, TARGET_SINGLE, 32'h7));
        send_header(hdr(32'h0, 32'h11, 8'h04, TARGET_SINGLE, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h05, TARGET_SINGLE, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h06, TARGET_SINGLE, 32'h0));
        send_header(hdr(32'h0, 32'h11, 8'h01, TARGET_ALL, 32'h0));
        wait_idle(SOURCE_ENTRIES + 8);

        set_regs(32'h0000_1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0009);
        send_header(hdr(32'h0000_1234, 32'hFFFF_FFFF, 8'hFF, TARGET_SINGLE, 32'hFFFF_FFFF));
        send_header(hdr(32'hFFFF_FFFF, 32'h22, 8'h00, TARGET_ALL, 32'h0));
        send_header(hdr(32'h0, 32'h33, 8'h00, TARGET_SINGLE, 32'hFFFF_FFFF));
        send_header(hdr(32'hFFFF_FFFE, 32'h33, 8'hFF, 2'd3, 32'h0));
        wait_idle(SOURCE_ENTRIES + 8);

        // Own ID equal to the default ID accepts any user; new senders cycle the victims.
        set_regs(32'h0000_0055, 32'h0000_0000, 32'h0000_0000, 32'h0000_0055);
        for (int k = 0; k < 8; k++)
            send_header(hdr(32'hDEAD_BEEF, 32'h100 + k, 8'h00, TARGET_ALL, 32'h0));
        send_header(hdr(32'hDEAD_BEEF, 32'h0, 8'h00, TARGET_SINGLE, 32'h0));
        wait_idle(SOURCE_ENTRIES + 8);

        set_regs(32'h0000_00A5, 32'h0000_1001, 32'hFFFF_FFFF, 32'h0000_0000);
        run_phase(1'b0);
        wait_idle(SOURCE_ENTRIES + 8);

        set_regs(32'h0, 32'h0, 32'h0, 32'h0);
        run_phase(1'b1);
        wait_idle(SOURCE_ENTRIES + 8);

        // A stretch with the sender never idling.
        steady = 1'b1;
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(1'b0);
        wait_idle(SOURCE_ENTRIES + 8);
        steady = 1'b0;

        set_regs($urandom, $urandom, $urandom, $urandom);
        run_phase(1'b0);
        wait_idle(SOURCE_ENTRIES + 8);

        set_regs(32'h8000_0001, $urandom, 32'h8000_0001, 32'h7FFF_FFFE);
        run_phase(1'b1);
        wait_idle(SOURCE_ENTRIES + 8);

        $display("tb_top: %0d messages over %0d register settings in %0d cycles",
                 sent, settings + 1, cycle_count);
        $display(
            "tb_top: %0d complete, %0d user error, %0d repeat, %0d target error, %0d no command",
            tally[ST_COMPLETE], tally[ST_USER_ERR], tally[ST_REPEAT],
            tally[ST_TARGET_ERR], tally[ST_NO_CMD]);
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mtdf_pkg.sv
rtl/mtdf_ram.sv
rtl/message_target_and_duplicate_filter.sv
verif/header_filter_checker.sv
verif/tb_top.sv
